[src/polygon_raster_point_test_top_defines.svh]
// Assertion macros for the polygon point test checker.
`ifndef POLYGON_RASTER_POINT_TEST_TOP_DEFINES_SVH
`define POLYGON_RASTER_POINT_TEST_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define PRC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define PRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/prc_pkg.sv]
// Shared types and item codes of the polygon point test block.
package prc_pkg;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_TEST  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [11:0]        pixel_col;
        logic [11:0]        pixel_row;
    } t_in_item;

    typedef struct packed {
        logic               inside_res;
        logic signed [11:0] box_left;
        logic signed [11:0] box_top;
        logic [12:0]        box_width;
        logic [12:0]        box_height;
        logic [6:0]         vertex_count;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] left_full;
        logic signed [15:0] top_full;
        logic signed [11:0] box_left;
        logic signed [11:0] box_top;
        logic [12:0]        box_width;
        logic [12:0]        box_height;
    } t_box_info;

    typedef struct packed {
        logic adv;
        logic active;
        logic wr_vtx;
        logic wr_prev;
    } t_cell_ctrl;

endpackage

[src/prc_stream_if.sv]
// Valid/ready stream interface carrying one payload item per transaction.
interface prc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/prc_box.sv]
// Bounding box in whole pixels from the fixed-point vertex extremes.
module prc_box import prc_pkg::*; #(
    parameter int FRACTION_BITS = 4
) (
    input  logic signed [15:0] i_min_x,
    input  logic signed [15:0] i_max_x,
    input  logic signed [15:0] i_min_y,
    input  logic signed [15:0] i_max_y,
    input  logic               i_nonempty,
    output t_box_info          o_box
);

    localparam logic signed [16:0] ROUND = 17'((1 << FRACTION_BITS) - 1);

    logic signed [15:0] floor_x, floor_y;
    logic signed [16:0] ceil_x, ceil_y;
    logic signed [17:0] width, height;

    assign floor_x = i_min_x >>> FRACTION_BITS;
    assign floor_y = i_min_y >>> FRACTION_BITS;
    assign ceil_x  = (17'(i_max_x) + ROUND) >>> FRACTION_BITS;
    assign ceil_y  = (17'(i_max_y) + ROUND) >>> FRACTION_BITS;
    assign width   = 18'(ceil_x) - 18'(floor_x) + 18'sd1;
    assign height  = 18'(ceil_y) - 18'(floor_y) + 18'sd1;

    always_comb begin
        o_box = '0;
        if (i_nonempty) begin
            o_box.left_full  = floor_x;
            o_box.top_full   = floor_y;
            o_box.box_left   = 12'(floor_x);
            o_box.box_top    = 12'(floor_y);
            o_box.box_width  = 13'(width);
            o_box.box_height = 13'(height);
        end
    end

endmodule

[src/prc_edge_cell.sv]
// One polygon edge cell: holds an edge and toggles the passing point's parity.
module prc_edge_cell import prc_pkg::*; #(
    parameter int PT_W = 22
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic signed [15:0]     i_vtx_x,
    input  logic signed [15:0]     i_vtx_y,
    input  logic signed [15:0]     i_prev_x,
    input  logic signed [15:0]     i_prev_y,
    input  logic                   i_tok_valid,
    input  logic signed [PT_W-1:0] i_tok_px,
    input  logic signed [PT_W-1:0] i_tok_py,
    input  logic                   i_tok_parity,
    output logic                   o_tok_valid,
    output logic signed [PT_W-1:0] o_tok_px,
    output logic signed [PT_W-1:0] o_tok_py,
    output logic                   o_tok_parity
);

    localparam int DW = PT_W + 1;

    // edge end points: i is this vertex, j the one before it
    logic signed [15:0] r_xi, r_yi, r_xj, r_yj;

    logic                   r_a_valid, r_a_parity, r_a_straddle, r_a_dpos;
    logic signed [PT_W-1:0] r_a_px, r_a_py;
    logic signed [2*DW-1:0] r_a_lhs, r_a_rhs;

    logic                   r_b_valid, r_b_parity;
    logic signed [PT_W-1:0] r_b_px, r_b_py;

    logic signed [DW-1:0]   dx_p, dy_p, dx_j, dy_j;
    logic signed [2*DW-1:0] n_lhs, n_rhs;
    logic                   n_straddle, n_cross;

    assign dx_p  = DW'(i_tok_px) - DW'(r_xi);
    assign dy_p  = DW'(i_tok_py) - DW'(r_yi);
    assign dx_j  = DW'(r_xj) - DW'(r_xi);
    assign dy_j  = DW'(r_yj) - DW'(r_yi);
    assign n_lhs = dx_p * dy_j;
    assign n_rhs = dx_j * dy_p;

    assign n_straddle = i_ctrl.active && ((r_yi > i_tok_py) != (r_yj > i_tok_py));
    assign n_cross    = r_a_straddle &&
                        (r_a_dpos ? (r_a_lhs < r_a_rhs) : (r_a_lhs > r_a_rhs));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_vtx) begin
            r_xi <= i_vtx_x;
            r_yi <= i_vtx_y;
        end
        if (i_ctrl.wr_prev) begin
            r_xj <= i_prev_x;
            r_yj <= i_prev_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_ctrl.adv) begin
            r_a_valid <= i_tok_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_a_px       <= i_tok_px;
            r_a_py       <= i_tok_py;
            r_a_parity   <= i_tok_parity;
            r_a_straddle <= n_straddle;
            r_a_dpos     <= r_yj > r_yi;
            r_a_lhs      <= n_lhs;
            r_a_rhs      <= n_rhs;
            r_b_px       <= r_a_px;
            r_b_py       <= r_a_py;
            r_b_parity   <= r_a_parity ^ n_cross;
        end
    end

    assign o_tok_valid  = r_b_valid;
    assign o_tok_px     = r_b_px;
    assign o_tok_py     = r_b_py;
    assign o_tok_parity = r_b_parity;

endmodule

[src/polygon_raster_point_test_top.sv]
// Top level of the even-odd polygon point tester with its edge cell chain.
//
//  channel | dir | transaction                       | payload
//  --------+-----+-----------------------------------+-------------------------------
//  i_in    | in  | i_in.valid && i_in.ready          | t_in_item: kind, coord, pixel
//  o_out   | out | o_out.valid && o_out.ready        | t_out_item: parity, box, count
//
//  Clear, add and the unused kind are answered in the cycle after they are accepted.
//  A test walks the chain, two register stages per cell, then the output register.
//  Tests stream one per cycle; clear and add wait until the chain drains.
//  Vertex storage is never cleared; only the count and the extremes are.
//  A stalled output freezes the whole chain and the input side.
module polygon_raster_point_test_top import prc_pkg::*; #(
    parameter int MAX_VERTICES  = 64,
    parameter int FRACTION_BITS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prc_stream_if.sink   i_in,
    prc_stream_if.source o_out
);

    // point width: whole-pixel sum fits 18 bits, then scaled to fixed point
    localparam int PT_W = 18 + FRACTION_BITS;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int IW   = $clog2(2 * MAX_VERTICES + 2);

    // polygon state
    logic [CW-1:0]      r_count;
    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [15:0] r_last_x, r_last_y;

    // flow control and output register
    logic [IW-1:0] r_inflight;
    logic          r_out_valid, r_out_inside, r_out_ovf;

    logic      adv, is_test, in_acc, test_acc, store_add, chain_exit;
    t_box_info box;

    logic                   tok_valid  [MAX_VERTICES+1];
    logic signed [PT_W-1:0] tok_px     [MAX_VERTICES+1];
    logic signed [PT_W-1:0] tok_py     [MAX_VERTICES+1];
    logic                   tok_parity [MAX_VERTICES+1];

    // advance everything whenever the output register can take new data
    assign adv        = !r_out_valid || o_out.ready;
    assign is_test    = i_in.data.kind == KIND_TEST;
    // only tests may overtake; anything that alters state waits for an empty chain
    assign i_in.ready = adv && (is_test || (r_inflight == '0));
    assign in_acc     = i_in.valid && i_in.ready;
    assign test_acc   = in_acc && is_test;
    assign store_add  = in_acc && (i_in.data.kind == KIND_ADD) &&
                        (r_count < CW'(MAX_VERTICES));
    assign chain_exit = adv && tok_valid[MAX_VERTICES];

    prc_box #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_box (
        .i_min_x   (r_min_x),
        .i_max_x   (r_max_x),
        .i_min_y   (r_min_y),
        .i_max_y   (r_max_y),
        .i_nonempty(r_count != '0),
        .o_box     (box)
    );

    // form the test point in fixed point from the box corner and offsets
    assign tok_valid[0]  = test_acc;
    assign tok_px[0]     = (PT_W'(box.left_full) + PT_W'($signed({1'b0, i_in.data.pixel_col})))
                           <<< FRACTION_BITS;
    assign tok_py[0]     = (PT_W'(box.top_full) + PT_W'($signed({1'b0, i_in.data.pixel_row})))
                           <<< FRACTION_BITS;
    assign tok_parity[0] = 1'b0;

    // cell k holds edge (k-1, k); cell 0 holds the closing edge from the last vertex
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        t_cell_ctrl         ctrl;
        logic signed [15:0] prev_x, prev_y;

        assign ctrl.adv     = adv;
        assign ctrl.active  = CW'(k) < r_count;
        assign ctrl.wr_vtx  = store_add && (r_count == CW'(k));
        assign ctrl.wr_prev = store_add && ((r_count == CW'(k)) || (k == 0));

        if (k == 0) begin : g_close
            assign prev_x = i_in.data.coord_x;
            assign prev_y = i_in.data.coord_y;
        end else begin : g_link
            assign prev_x = r_last_x;
            assign prev_y = r_last_y;
        end

        prc_edge_cell #(
            .PT_W(PT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_vtx_x     (i_in.data.coord_x),
            .i_vtx_y     (i_in.data.coord_y),
            .i_prev_x    (prev_x),
            .i_prev_y    (prev_y),
            .i_tok_valid (tok_valid[k]),
            .i_tok_px    (tok_px[k]),
            .i_tok_py    (tok_py[k]),
            .i_tok_parity(tok_parity[k]),
            .o_tok_valid (tok_valid[k+1]),
            .o_tok_px    (tok_px[k+1]),
            .o_tok_py    (tok_py[k+1]),
            .o_tok_parity(tok_parity[k+1])
        );
    end

    // polygon state: clear empties, add appends and widens the box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else if (in_acc) begin
            unique case (i_in.data.kind)
                KIND_CLEAR: begin
                    r_count <= '0;
                    r_min_x <= '0;
                    r_max_x <= '0;
                    r_min_y <= '0;
                    r_max_y <= '0;
                end
                KIND_ADD: begin
                    if (store_add) begin
                        r_count <= r_count + CW'(1);
                        if (r_count == '0) begin
                            r_min_x <= i_in.data.coord_x;
                            r_max_x <= i_in.data.coord_x;
                            r_min_y <= i_in.data.coord_y;
                            r_max_y <= i_in.data.coord_y;
                        end else begin
                            if (i_in.data.coord_x < r_min_x) r_min_x <= i_in.data.coord_x;
                            if (i_in.data.coord_x > r_max_x) r_max_x <= i_in.data.coord_x;
                            if (i_in.data.coord_y < r_min_y) r_min_y <= i_in.data.coord_y;
                            if (i_in.data.coord_y > r_max_y) r_max_y <= i_in.data.coord_y;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // keep the newest stored vertex as the start of the next edge
    always_ff @(posedge i_clk) begin
        if (store_add) begin
            r_last_x <= i_in.data.coord_x;
            r_last_y <= i_in.data.coord_y;
        end
    end

    // count tests inside the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + IW'(test_acc) - IW'(chain_exit);
        end
    end

    // output register: a finished test or the immediate answer of any other item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tok_valid[MAX_VERTICES] || (in_acc && !is_test);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_inside <= tok_valid[MAX_VERTICES] && tok_parity[MAX_VERTICES];
            r_out_ovf    <= in_acc && (i_in.data.kind == KIND_ADD) && !store_add;
        end
    end

    // box and count hold still while tests are in flight, so read them live
    assign o_out.valid             = r_out_valid;
    assign o_out.data.inside_res   = r_out_inside;
    assign o_out.data.box_left     = box.box_left;
    assign o_out.data.box_top      = box.box_top;
    assign o_out.data.box_width    = box.box_width;
    assign o_out.data.box_height   = box.box_height;
    assign o_out.data.vertex_count = 7'(r_count);
    assign o_out.data.overflow     = r_out_ovf;

endmodule

[src/prc_checker.sv]
// Port-level checker for the polygon point tester and its bind.
`include "polygon_raster_point_test_top_defines.svh"

module prc_checker import prc_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_kind,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_out_item  i_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    `PRC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    `PRC_ASSERT_NEXT(a_clear_result, in_acc && (i_in_kind == KIND_CLEAR), i_out_valid && (i_out_data.vertex_count == 7'd0) && (i_out_data.box_width == 13'd0))
    `PRC_ASSERT_SAME(a_ovf_full, i_out_valid && i_out_data.overflow, (i_out_data.vertex_count == 7'(MAX_VERTICES)) && !i_out_data.inside_res)

endmodule

bind polygon_raster_point_test_top prc_checker #(
    .MAX_VERTICES(MAX_VERTICES)
) u_prc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_in_kind  (i_in.data.kind),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data)
);

[test/prc_point_check_pkg.sv]
// Result tracking and prediction of the polygon point tester for the testbench.
package prc_point_check_pkg;
    import prc_pkg::*;

    localparam int VERTEX_SLOTS = 64;
    localparam int FRAC_BITS    = 4;
    localparam int PRINT_CAP    = 60;

    // Kind code that the block treats as a no-op.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    class parity_scoreboard;
        int          vert_x[VERTEX_SLOTS];
        int          vert_y[VERTEX_SLOTS];
        int unsigned vert_count;
        int          min_x, max_x, min_y, max_y;
        int          box_w, box_h;
        t_out_item   awaited_answers[$];
        int unsigned mismatches;

        function new();
            vert_count = 0;
            min_x      = 0;
            max_x      = 0;
            min_y      = 0;
            max_y      = 0;
            box_w      = 0;
            box_h      = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        function int unsigned outstanding();
            return awaited_answers.size();
        endfunction

        // Even-odd crossing count of a ray toward +x, closing edge included.
        function bit ray_parity(longint px, longint py);
            bit          odd;
            int unsigned j;
            longint      xi, yi, xj, yj, d, lhs, rhs;
            odd = 1'b0;
            if (vert_count == 0) begin
                return 1'b0;
            end
            j = vert_count - 1;
            for (int unsigned i = 0; i < vert_count; i++) begin
                xi = vert_x[i];
                yi = vert_y[i];
                xj = vert_x[j];
                yj = vert_y[j];
                if ((yi > py) != (yj > py)) begin
                    d   = yj - yi;
                    lhs = (px - xi) * d;
                    rhs = (xj - xi) * (py - yi);
                    if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) begin
                        odd = !odd;
                    end
                end
                j = i;
            end
            return odd;
        endfunction

        function void note_input(t_in_item it);
            t_out_item ans;
            int        cx, cy, left, top;
            ans = '0;
            cx  = $signed(it.coord_x);
            cy  = $signed(it.coord_y);
            case (it.kind)
                KIND_CLEAR: begin
                    vert_count = 0;
                    min_x      = 0;
                    max_x      = 0;
                    min_y      = 0;
                    max_y      = 0;
                end
                KIND_ADD: begin
                    if (vert_count < VERTEX_SLOTS) begin
                        vert_x[vert_count] = cx;
                        vert_y[vert_count] = cy;
                        if (vert_count == 0) begin
                            min_x = cx;
                            max_x = cx;
                            min_y = cy;
                            max_y = cy;
                        end else begin
                            if (cx < min_x) min_x = cx;
                            if (cx > max_x) max_x = cx;
                            if (cy < min_y) min_y = cy;
                            if (cy > max_y) max_y = cy;
                        end
                        vert_count++;
                    end else begin
                        ans.overflow = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            left  = 0;
            top   = 0;
            box_w = 0;
            box_h = 0;
            if (vert_count > 0) begin
                left  = min_x >>> FRAC_BITS;
                top   = min_y >>> FRAC_BITS;
                box_w = -((-max_x) >>> FRAC_BITS) - left + 1;
                box_h = -((-max_y) >>> FRAC_BITS) - top + 1;
            end
            if (it.kind == KIND_TEST && vert_count > 0) begin
                ans.inside_res = ray_parity(
                    (longint'(left) + longint'(it.pixel_col)) * (longint'(1) << FRAC_BITS),
                    (longint'(top) + longint'(it.pixel_row)) * (longint'(1) << FRAC_BITS));
            end
            ans.box_left     = 12'(left);
            ans.box_top      = 12'(top);
            ans.box_width    = 13'(box_w);
            ans.box_height   = 13'(box_h);
            ans.vertex_count = 7'(vert_count);
            awaited_answers  = {awaited_answers, ans};
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (awaited_answers.size() == 0) begin
                report($sformatf("result with nothing awaited: %p", got));
                return;
            end
            want = awaited_answers.pop_front();
            if (got.inside_res !== want.inside_res)
                report($sformatf("inside_res %0b, want %0b", got.inside_res, want.inside_res));
            if (got.box_left !== want.box_left)
                report($sformatf("box_left %0d, want %0d", got.box_left, want.box_left));
            if (got.box_top !== want.box_top)
                report($sformatf("box_top %0d, want %0d", got.box_top, want.box_top));
            if (got.box_width !== want.box_width)
                report($sformatf("box_width %0d, want %0d", got.box_width, want.box_width));
            if (got.box_height !== want.box_height)
                report($sformatf("box_height %0d, want %0d", got.box_height, want.box_height));
            if (got.vertex_count !== want.vertex_count)
                report($sformatf("vertex_count %0d, want %0d",
                                 got.vertex_count, want.vertex_count));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
        endtask
    endclass

endpackage

[test/tb_top.sv]
// Testbench top: drives polygon builds and pixel tests, checks every result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;
    import prc_point_check_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    // A test walks two register stages per edge cell plus one.
    localparam int CHAIN_CYCLES = 2 * VERTEX_SLOTS + 1;
    // Slowest run: every item waits out the chain plus long stalls on both sides.
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic i_clk;
    logic i_rst_n;

    prc_stream_if #(.T(t_in_item))  in_ch ();
    prc_stream_if #(.T(t_out_item)) out_ch ();

    // High while neither side idles at random.
    bit               steady;
    int unsigned      items_sent;
    parity_scoreboard sb;

    polygon_raster_point_test_top #(
        .MAX_VERTICES (VERTEX_SLOTS),
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall the result side at random about 30 percent of the time, except in the steady stretch.
    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= 30);
    end

    // Check each result transaction against the oldest awaited answer.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.data);
        end
    end

    // Watchdog: end the run if it never drains.
    initial begin
        for (int unsigned n = 0; n < CYCLE_LIMIT; n++) begin
            @(posedge i_clk);
        end
        $display("[%0t] run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_in_item build(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                                       logic [11:0] col, logic [11:0] row);
        t_in_item it;
        it.kind      = kind;
        it.coord_x   = x;
        it.coord_y   = y;
        it.pixel_col = col;
        it.pixel_row = row;
        return it;
    endfunction

    // Pick a vertex coordinate near center; now and then snap it to a whole
    // pixel so rays pass exactly through vertices and horizontal edges show up.
    function automatic logic [15:0] pick_coord(int center, int span);
        int v;
        if ($urandom_range(15) == 0) begin
            return 16'($urandom);
        end
        v = center + int'($urandom_range(2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        if ($urandom_range(1) == 1) v = v & ~15;
        return v[15:0];
    endfunction

    // Pick a pixel offset inside the current box, with some anywhere in range.
    function automatic logic [11:0] pick_offset(int extent);
        if (extent <= 0 || $urandom_range(9) == 0) begin
            return 12'($urandom_range(4095));
        end
        return (extent > 4095) ? 12'($urandom_range(4095)) : 12'($urandom_range(extent));
    endfunction

    function automatic t_in_item pixel_probe();
        return build(KIND_TEST, 16'($urandom), 16'($urandom),
                     pick_offset(sb.box_w), pick_offset(sb.box_h));
    endfunction

    // Present one item, idling at random first; note it once the transaction happens.
    task automatic send_item(t_in_item it);
        while (!steady && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold the input idle until every awaited answer has come back.
    task automatic wait_for_answers();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic send_add(logic [15:0] x, logic [15:0] y);
        send_item(build(KIND_ADD, x, y, 12'($urandom), 12'($urandom)));
    endtask

    task automatic send_test(logic [11:0] col, logic [11:0] row);
        send_item(build(KIND_TEST, 16'($urandom), 16'($urandom), col, row));
    endtask

    task automatic send_clear();
        send_item(build(KIND_CLEAR, 16'($urandom), 16'($urandom),
                        12'($urandom), 12'($urandom)));
    endtask

    task automatic run_directed();
        // Empty store: zero box, never inside; the spare kind changes nothing.
        send_test(12'd5, 12'd7);
        send_item(build(KIND_SPARE, 16'h0000, 16'h0000, 12'd0, 12'd0));
        // Extreme corners: box spans the whole coordinate range.
        send_add(16'h8000, 16'h8000);
        send_add(16'h7fff, 16'h8000);
        send_add(16'h7fff, 16'h7fff);
        send_test(12'd0, 12'd0);
        send_test(12'd4095, 12'd4095);
        send_test(12'd4000, 12'd100);
        send_item(build(KIND_SPARE, 16'hffff, 16'hffff, 12'hfff, 12'hfff));
        send_clear();
        send_test(12'd0, 12'd0);
        // Grow from one vertex to three with fractional coordinates, probing after each add.
        send_add(16'h0011, 16'h0021);
        send_test(12'd0, 12'd0);
        send_add(-16'sh0019, 16'h0050);
        send_test(12'd1, 12'd2);
        send_add(16'h00a0, 16'h00a0);
        send_test(12'd3, 12'd4);
        // Another probe of the same triangle.
        send_test(12'd1, 12'd5);
        send_clear();
        // Square with horizontal edges; probe a corner and the middle.
        send_add(16'h0000, 16'h0000);
        send_add(16'h00a0, 16'h0000);
        send_add(16'h00a0, 16'h00a0);
        send_add(16'h0000, 16'h00a0);
        send_test(12'd0, 12'd0);
        send_test(12'd5, 12'd5);
    endtask

    // Build random polygons and probe them; the first build overruns the store.
    task automatic run_random();
        int          spans[5];
        int unsigned first_item;
        int unsigned nverts;
        int unsigned ntests;
        int          span;
        int          center;
        bit          first_build;
        spans       = '{48, 192, 960, 6400, 32000};
        first_item  = items_sent;
        first_build = 1'b1;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            steady = (items_sent - first_item >= 350) && (items_sent - first_item < 550);
            if ($urandom_range(9) == 0) begin
                wait_for_answers();
            end
            // Mostly start fresh; sometimes keep piling vertices onto the old polygon.
            if ($urandom_range(7) != 0) begin
                send_clear();
            end
            if (first_build || $urandom_range(29) == 0) begin
                nverts = VERTEX_SLOTS + 2;
            end else if ($urandom_range(19) == 0) begin
                nverts = $urandom_range(2, 1);
            end else begin
                nverts = $urandom_range(9, 3);
            end
            first_build = 1'b0;
            span   = spans[$urandom_range(4)];
            center = int'($urandom_range(48000)) - 24000;
            for (int unsigned v = 0; v < nverts; v++) begin
                send_add(pick_coord(center, span), pick_coord(center, span));
                if ($urandom_range(5) == 0) begin
                    send_item(pixel_probe());
                end
            end
            ntests = $urandom_range(30, 6);
            for (int unsigned t = 0; t < ntests; t++) begin
                if ($urandom_range(49) == 0) begin
                    send_item(build(KIND_SPARE, 16'($urandom), 16'($urandom),
                                    12'($urandom), 12'($urandom)));
                end else begin
                    send_item(pixel_probe());
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        sb           = new();
        steady       = 1'b0;
        items_sent   = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        // Pause the sender until the directed part has fully drained.
        wait_for_answers();
        run_random();

        // Drain, then give the chain time to show any stray result.
        wait_for_answers();
        repeat (CHAIN_CYCLES + 20) @(negedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[polygon_raster_point_test_top.f]
+incdir+src
src/prc_pkg.sv
src/prc_stream_if.sv
src/prc_box.sv
src/prc_edge_cell.sv
src/polygon_raster_point_test_top.sv
src/prc_checker.sv
test/prc_point_check_pkg.sv
test/tb_top.sv
